@@ sv/rc_pulse_width_decoder_core_defines.svh @@
// Assertion macros for the RC pulse width decoder core.
// Needs clk and rst_n in the scope of the module that uses them.
`ifndef RC_PULSE_WIDTH_DECODER_CORE_DEFINES_SVH
`define RC_PULSE_WIDTH_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define RPWD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define RPWD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPWD_ASSERT(label, prop, msg)
`define RPWD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ sv/rpwd_pkg.sv @@
// Shared types and constants for the RC pulse width decoder.
// No dependencies; used by rpwd_mul, rpwd_div and the core.
package rpwd_pkg;

  // capture timer width; the low TS_W bits of a timestamp are used
  localparam int TS_W = 32;
  localparam logic [31:0] TS_MASK = 32'((64'd1 << TS_W) - 64'd1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SCALED_W = 17;
  localparam int PW_W     = 31;

  // serial units: 2-bit digit multiply over 32 bits, 1 bit per step divide
  localparam int MUL_STEPS = 16;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [31:0] RST_COUNTER_TOP = 32'hffff_ffff;
  localparam logic [31:0] RST_TICK_SCALE  = 32'd65536;
  localparam logic [19:0] RST_PERIOD_US   = 20'd17500;
  localparam logic [15:0] RST_FULL_REV_US = 16'd1000;
  localparam logic [15:0] RST_NEUTRAL_US  = 16'd1500;
  localparam logic [15:0] RST_FULL_FWD_US = 16'd2000;
  localparam logic [15:0] RST_FWD_MAG     = 16'd100;
  localparam logic [15:0] RST_REV_MAG     = 16'd100;

  localparam logic [PW_W-1:0] PW_MAX = {PW_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COUNTER_TOP = 3'd0,
    REG_TICK_SCALE  = 3'd1,
    REG_PERIOD_US   = 3'd2,
    REG_FULL_REV_US = 3'd3,
    REG_NEUTRAL_US  = 3'd4,
    REG_FULL_FWD_US = 3'd5,
    REG_FWD_MAG     = 3'd6,
    REG_REV_MAG     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, result valid from here until next start
  } unit_stat_t;

endpackage

@@ sv/rpwd_mul.sv @@
// Digit-serial 32x32 unsigned multiplier, two multiplier bits per cycle.
// Depends on rpwd_pkg.
module rpwd_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output rpwd_pkg::unit_stat_t stat,
  output logic [63:0]         product
);

  logic                           busy_r, busy_nxt;
  logic                           prep_r, prep_nxt;
  logic                           done_r, done_nxt;
  logic [rpwd_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]                    a_r, a_nxt;
  logic [33:0]                    a3_r, a3_nxt;
  logic [31:0]                    hi_r, hi_nxt;
  logic [31:0]                    lo_r, lo_nxt;
  logic [33:0]                    addend;
  logic [33:0]                    sum;

  always_comb begin
    case (lo_r[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, a_r};
      2'd2:    addend = {1'b0, a_r, 1'b0};
      2'd3:    addend = a3_r;
      default: addend = '0;
    endcase
    sum = {2'b00, hi_r} + addend;
  end

  always_comb begin
    busy_nxt = busy_r;
    prep_nxt = prep_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    a3_nxt   = a3_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      prep_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a;
      hi_nxt   = '0;
      lo_nxt   = b;
    end else if (prep_r) begin
      prep_nxt = 1'b0;
      a3_nxt   = {2'b00, a_r} + {1'b0, a_r, 1'b0};
    end else if (busy_r) begin
      // shift-right accumulate: low product bits fall into lo_r
      hi_nxt  = sum[33:2];
      lo_nxt  = {sum[1:0], lo_r[31:2]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rpwd_pkg::MUL_CNT_W'(rpwd_pkg::MUL_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      prep_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      prep_r <= prep_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r  <= a_nxt;
    a3_r <= a3_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = {hi_r, lo_r};

endmodule

@@ sv/rpwd_div.sv @@
// Bit-serial restoring divider, 16-bit quotient, one bit per cycle.
// The starting remainder must be below the divisor. Depends on rpwd_pkg.
module rpwd_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [15:0]         rem_in,
  input  logic [15:0]         num_lo,
  input  logic [15:0]         den,
  output rpwd_pkg::unit_stat_t stat,
  output logic [15:0]         quot
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [rpwd_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]                    rem_r, rem_nxt;
  logic [15:0]                    sh_r, sh_nxt;
  logic [15:0]                    den_r, den_nxt;
  logic [17:0]                    trial;
  logic                           ge;

  assign trial = {1'b0, rem_r, sh_r[15]} - {2'b00, den_r};
  assign ge    = !trial[17];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = rem_in;
      sh_nxt   = num_lo;
      den_nxt  = den;
    end else if (busy_r) begin
      // dividend bits shift out of sh_r as quotient bits shift in
      rem_nxt = ge ? trial[15:0] : {rem_r[14:0], sh_r[15]};
      sh_nxt  = {sh_r[14:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rpwd_pkg::DIV_CNT_W'(rpwd_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = sh_r;

endmodule

@@ sv/rc_pulse_width_decoder_core.sv @@
// RC pulse width decoder core. The first capture of a pair is registered.
// The second runs through two multiplier passes and the 16-step divider,
// with the steps S_DIFF, S_FOLD, S_CENTRE, S_SIGN, S_CHK and S_OUT around them.
// Zero or negative range: S_SIGN goes straight to S_OUT; quotient past 16 bits: S_CHK does.
// One item in flight, next beat taken once back in S_IDLE; a held output
// register stalls the core. Sync active-low reset restores register defaults.
`include "rc_pulse_width_decoder_core_defines.svh"

module rc_pulse_width_decoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [31:0]                         in_capture_timestamp,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rpwd_pkg::SCALED_W-1:0] out_scaled_value,
  output logic [rpwd_pkg::PW_W-1:0]           out_pulse_width_us,
  input  logic                                cfg_we,
  input  logic [rpwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpwd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DIFF   = 10'b00_0000_0010,
    S_MUL1   = 10'b00_0000_0100,
    S_FOLD   = 10'b00_0000_1000,
    S_CENTRE = 10'b00_0001_0000,
    S_SIGN   = 10'b00_0010_0000,
    S_MUL2   = 10'b00_0100_0000,
    S_CHK    = 10'b00_1000_0000,
    S_DIV    = 10'b01_0000_0000,
    S_OUT    = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] top_r, scale_r;
  logic [19:0] period_r;
  logic [15:0] frev_r, neut_r, ffwd_r, fmag_r, rmag_r;

  logic        awaiting_r, awaiting_nxt;
  logic [31:0] first_r, first_nxt;
  logic [31:0] d0_r, d0_nxt;
  logic        wrap_r, wrap_nxt;
  logic [30:0] us_r, us_nxt;
  logic signed [31:0] width_r, width_nxt;
  logic signed [32:0] centred_r, centred_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] rng_r, rng_nxt;
  logic [15:0] cap_r, cap_nxt;
  logic [16:0] res_r, res_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [16:0] out_scaled_r, out_scaled_nxt;
  logic [30:0] out_pw_r, out_pw_nxt;

  logic [31:0] stamp;
  logic        in_beat;

  logic        mul_start;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  rpwd_pkg::unit_stat_t mul_stat;

  logic        div_start;
  logic [15:0] div_q;
  rpwd_pkg::unit_stat_t div_stat;

  logic [31:0] diff;
  logic [32:0] mag33;
  logic [16:0] fwd_rng, rev_rng, sel_rng;
  logic [15:0] sel_cap;
  logic [15:0] q_capped;

  function automatic logic [16:0] apply_sign(input logic neg, input logic [15:0] v);
    logic [16:0] ext;
    ext = {1'b0, v};
    return neg ? 17'(-ext) : ext;
  endfunction

  assign stamp   = in_capture_timestamp & rpwd_pkg::TS_MASK;
  assign in_ready = (state_r == S_IDLE);
  assign in_beat = in_valid && in_ready;

  // wrap case: top - first + stamp + 1 == (stamp - first) + top + 1
  assign diff     = wrap_r ? (d0_r + top_r + 32'd1) : d0_r;
  assign mag33    = centred_r[32] ? 33'(-centred_r) : 33'(centred_r);
  assign fwd_rng  = {1'b0, ffwd_r} - {1'b0, neut_r};
  assign rev_rng  = {1'b0, neut_r} - {1'b0, frev_r};
  assign sel_rng  = centred_r[32] ? rev_rng : fwd_rng;
  assign sel_cap  = centred_r[32] ? rmag_r : fmag_r;
  assign q_capped = (div_q > cap_r) ? cap_r : div_q;

  always_comb begin
    state_nxt     = state_r;
    awaiting_nxt  = awaiting_r;
    first_nxt     = first_r;
    d0_nxt        = d0_r;
    wrap_nxt      = wrap_r;
    us_nxt        = us_r;
    width_nxt     = width_r;
    centred_nxt   = centred_r;
    neg_nxt       = neg_r;
    rng_nxt       = rng_r;
    cap_nxt       = cap_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_scaled_nxt = out_scaled_r;
    out_pw_nxt    = out_pw_r;
    mul_start     = 1'b0;
    mul_a         = diff;
    mul_b         = scale_r;
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (awaiting_r) begin
            first_nxt    = stamp;
            awaiting_nxt = 1'b0;
          end else begin
            awaiting_nxt = 1'b1;
            d0_nxt       = stamp - first_r;
            wrap_nxt     = first_r > stamp;
            state_nxt    = S_DIFF;
          end
        end
      end
      S_DIFF: begin
        mul_start = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        if (mul_stat.done) begin
          // product >> 16, saturated to 31 bits
          us_nxt    = (|mul_p[63:47]) ? rpwd_pkg::PW_MAX : mul_p[46:16];
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        if (us_r > {12'd0, period_r[19:1]})
          width_nxt = $signed({12'd0, period_r}) - $signed({1'b0, us_r});
        else
          width_nxt = $signed({1'b0, us_r});
        state_nxt = S_CENTRE;
      end
      S_CENTRE: begin
        centred_nxt = $signed({width_r[31], width_r}) - $signed({17'd0, neut_r});
        state_nxt   = S_SIGN;
      end
      S_SIGN: begin
        neg_nxt = centred_r[32];
        rng_nxt = sel_rng[15:0];
        cap_nxt = sel_cap;
        if (sel_rng[16] || sel_rng == 17'd0) begin
          res_nxt   = apply_sign(centred_r[32], sel_cap);
          state_nxt = S_OUT;
        end else begin
          mul_start = 1'b1;
          mul_a     = mag33[31:0];
          mul_b     = {16'd0, sel_cap};
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mul_stat.done)
          state_nxt = S_CHK;
      end
      S_CHK: begin
        // quotient of 2^16 or more is past any cap
        if (mul_p[47:16] >= {16'd0, rng_r}) begin
          res_nxt   = apply_sign(neg_r, cap_r);
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_nxt   = apply_sign(neg_r, q_capped);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_scaled_nxt = res_r;
          out_pw_nxt     = width_r[31] ? '0 : width_r[30:0];
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      awaiting_r  <= 1'b1;
      first_r     <= '0;
      out_valid_r <= 1'b0;
      top_r       <= rpwd_pkg::RST_COUNTER_TOP;
      scale_r     <= rpwd_pkg::RST_TICK_SCALE;
      period_r    <= rpwd_pkg::RST_PERIOD_US;
      frev_r      <= rpwd_pkg::RST_FULL_REV_US;
      neut_r      <= rpwd_pkg::RST_NEUTRAL_US;
      ffwd_r      <= rpwd_pkg::RST_FULL_FWD_US;
      fmag_r      <= rpwd_pkg::RST_FWD_MAG;
      rmag_r      <= rpwd_pkg::RST_REV_MAG;
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          rpwd_pkg::REG_COUNTER_TOP: top_r    <= cfg_wdata;
          rpwd_pkg::REG_TICK_SCALE:  scale_r  <= cfg_wdata;
          rpwd_pkg::REG_PERIOD_US:   period_r <= cfg_wdata[19:0];
          rpwd_pkg::REG_FULL_REV_US: frev_r   <= cfg_wdata[15:0];
          rpwd_pkg::REG_NEUTRAL_US:  neut_r   <= cfg_wdata[15:0];
          rpwd_pkg::REG_FULL_FWD_US: ffwd_r   <= cfg_wdata[15:0];
          rpwd_pkg::REG_FWD_MAG:     fmag_r   <= cfg_wdata[15:0];
          rpwd_pkg::REG_REV_MAG:     rmag_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
    d0_r         <= d0_nxt;
    wrap_r       <= wrap_nxt;
    us_r         <= us_nxt;
    width_r      <= width_nxt;
    centred_r    <= centred_nxt;
    neg_r        <= neg_nxt;
    rng_r        <= rng_nxt;
    cap_r        <= cap_nxt;
    res_r        <= res_nxt;
    out_scaled_r <= out_scaled_nxt;
    out_pw_r     <= out_pw_nxt;
  end

  rpwd_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .stat    (mul_stat),
    .product (mul_p)
  );

  rpwd_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .rem_in (mul_p[31:16]),
    .num_lo (mul_p[15:0]),
    .den    (rng_r),
    .stat   (div_stat),
    .quot   (div_q)
  );

  assign out_valid          = out_valid_r;
  assign out_scaled_value   = $signed(out_scaled_r);
  assign out_pulse_width_us = out_pw_r;

  `RPWD_ASSERT(a_second_starts, (in_beat && !awaiting_r) |=> (state_r == S_DIFF), "no start")
  `RPWD_ASSERT(a_out_from_out_state, $rose(out_valid_r) |-> $past(state_r == S_OUT), "stray beat")
  `RPWD_ASSERT(a_fwd_cap, (out_valid_r && !out_scaled_r[16]) |-> (out_scaled_r[15:0] <= fmag_r), "cap")
  `RPWD_ASSERT(a_mul_done_state, mul_stat.done |-> (state_r == S_MUL1 || state_r == S_MUL2), "mul")
  `RPWD_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule
